// ----- hdl/chm_pkg.sv -----
// ============================================================================
// chm_pkg
// Shared types and constants of the chained hash key-value map unit.
// ============================================================================
package chm_pkg;

    // Table geometry; BUCKETS must be a power of two (hash is a low-bit select)
    localparam int BUCKETS  = 64;
    localparam int CAPACITY = 256;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int IDX_W  = SLOT_W + 1;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 9;

    // Slot index that marks the end of a chain or an empty bucket
    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_ALLOC,
        S_UNLINK,
        S_RESP
    } t_state;

    // Bucket head memory access
    typedef struct packed {
        logic [BKT_W-1:0] rd_addr;
        logic             wr_en;
        logic [BKT_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic             clr;
    } t_head_req;

    // Entry memory access; each field has its own write enable
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] wr_addr;
        logic              key_we;
        logic              val_we;
        logic              link_we;
        logic [KEY_W-1:0]  wr_key;
        logic [VAL_W-1:0]  wr_val;
        logic [IDX_W-1:0]  wr_link;
        logic              clr;
    } t_ent_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] link;
    } t_ent_rd;

endpackage

// ----- hdl/chained_hash_key_value_map_unit.sv -----
// Sequence: an accepted request reads its bucket head (S_HEAD), walks the
// chain (S_WALK) until the key matches and registers its result (S_RESP); an
// empty bucket or clear skips the walk, a miss walks the whole chain, a new
// insert or a non-head remove adds S_ALLOC or S_UNLINK. One request at a time.
// The bucket walk reads one entry per cycle through the single entry port.
// Reset: all buckets empty, free list restored at once, no clearing pass.
// ============================================================================
// chained_hash_key_value_map_unit
// Bounded key-value map with hashed buckets and chained entries: insert or
// update, get, remove and clear, each answered with one registered result.
// ============================================================================
module chained_hash_key_value_map_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic signed [31:0]            i_key,
    input  logic [31:0]                   i_data_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic [31:0]                   o_read_value,
    output logic [8:0]                    o_live_entries
);

    chm_pkg::t_head_req               w_head_req;
    logic [chm_pkg::IDX_W-1:0]        w_head_rd;
    chm_pkg::t_ent_req                w_ent_req;
    chm_pkg::t_ent_rd                 w_ent_rd;

    chm_pkg::t_state                  r_state, n_state;
    chm_pkg::t_op                     r_op, n_op;
    logic [chm_pkg::KEY_W-1:0]        r_key, n_key;
    logic [chm_pkg::VAL_W-1:0]        r_data, n_data;
    logic [chm_pkg::BKT_W-1:0]        r_bkt, n_bkt;
    logic [chm_pkg::IDX_W-1:0]        r_head, n_head;
    logic [chm_pkg::IDX_W-1:0]        r_cur, n_cur;
    logic [chm_pkg::IDX_W-1:0]        r_prev, n_prev;
    logic [chm_pkg::IDX_W-1:0]        r_link, n_link;
    logic [chm_pkg::IDX_W-1:0]        r_free, n_free;
    logic [chm_pkg::IDX_W-1:0]        r_total, n_total;
    chm_pkg::t_status                 r_status, n_status;
    logic                             r_found, n_found;
    logic [chm_pkg::VAL_W-1:0]        r_value, n_value;

    logic                             r_out_valid;
    logic [chm_pkg::STAT_W-1:0]       r_out_status;
    logic                             r_out_found;
    logic [chm_pkg::VAL_W-1:0]        r_out_value;
    logic [chm_pkg::CNT_W-1:0]        r_out_count;
    logic                             w_out_load;

    logic                             w_free_empty;
    chm_pkg::t_state                  w_miss_state;
    chm_pkg::t_status                 w_miss_status;

    chm_heads u_heads (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_head_req),
        .o_rd_data (w_head_rd)
    );

    chm_entries u_entries (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ent_req),
        .o_rd    (w_ent_rd)
    );

    // Key absent: insert allocates unless the pool is spent, others report
    assign w_free_empty  = (r_free >= chm_pkg::NIL);
    assign w_miss_state  = (r_op == chm_pkg::OP_INSERT && !w_free_empty) ?
                           chm_pkg::S_ALLOC : chm_pkg::S_RESP;
    assign w_miss_status = (r_op != chm_pkg::OP_INSERT) ? chm_pkg::STS_NOT_FOUND :
                           (w_free_empty ? chm_pkg::STS_FULL : chm_pkg::STS_OK);

    assign o_ready    = (r_state == chm_pkg::S_IDLE);
    assign w_out_load = (r_state == chm_pkg::S_RESP) && (!r_out_valid || i_ready);

    // Advance state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::S_IDLE;
            r_free  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_total <= n_total;
        end
    end

    // Hold request context and partial result
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_data   <= n_data;
        r_bkt    <= n_bkt;
        r_head   <= n_head;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_link   <= n_link;
        r_status <= n_status;
        r_found  <= n_found;
        r_value  <= n_value;
    end

    // Sequence head read, chain walk and write-back
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_data   = r_data;
        n_bkt    = r_bkt;
        n_head   = r_head;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_link   = r_link;
        n_free   = r_free;
        n_total  = r_total;
        n_status = r_status;
        n_found  = r_found;
        n_value  = r_value;

        w_head_req         = '0;
        w_head_req.rd_addr = r_bkt;
        w_head_req.wr_addr = r_bkt;

        w_ent_req         = '0;
        w_ent_req.rd_addr = r_cur[chm_pkg::SLOT_W-1:0];
        w_ent_req.wr_addr = r_cur[chm_pkg::SLOT_W-1:0];

        case (r_state)
            chm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op               = chm_pkg::t_op'(i_operation);
                    n_key              = i_key;
                    n_data             = i_data_word;
                    n_bkt              = i_key[chm_pkg::BKT_W-1:0];
                    w_head_req.rd_addr = i_key[chm_pkg::BKT_W-1:0];
                    n_status           = chm_pkg::STS_OK;
                    n_found            = 1'b0;
                    n_value            = '0;
                    n_state            = chm_pkg::S_HEAD;
                end
            end

            chm_pkg::S_HEAD: begin
                n_head = w_head_rd;
                n_prev = chm_pkg::NIL;
                if (r_op == chm_pkg::OP_CLEAR) begin
                    w_head_req.clr = 1'b1;
                    w_ent_req.clr  = 1'b1;
                    n_free         = '0;
                    n_total        = '0;
                    n_state        = chm_pkg::S_RESP;
                end else if (w_head_rd >= chm_pkg::NIL) begin
                    w_ent_req.rd_addr = r_free[chm_pkg::SLOT_W-1:0];
                    n_status          = w_miss_status;
                    n_state           = w_miss_state;
                end else begin
                    w_ent_req.rd_addr = w_head_rd[chm_pkg::SLOT_W-1:0];
                    n_cur             = w_head_rd;
                    n_state           = chm_pkg::S_WALK;
                end
            end

            chm_pkg::S_WALK: begin
                if (w_ent_rd.key == r_key) begin
                    case (r_op)
                        chm_pkg::OP_INSERT: begin
                            w_ent_req.val_we = 1'b1;
                            w_ent_req.wr_val = r_data;
                            n_state          = chm_pkg::S_RESP;
                        end
                        chm_pkg::OP_GET: begin
                            n_found = 1'b1;
                            n_value = w_ent_rd.value;
                            n_state = chm_pkg::S_RESP;
                        end
                        chm_pkg::OP_REMOVE: begin
                            // Push the slot onto the free list, then unlink it
                            n_found           = 1'b1;
                            w_ent_req.link_we = 1'b1;
                            w_ent_req.wr_link = r_free;
                            n_free            = r_cur;
                            n_total           = (r_total != '0) ?
                                                r_total - chm_pkg::IDX_W'(1) : r_total;
                            if (r_prev >= chm_pkg::NIL) begin
                                w_head_req.wr_en   = 1'b1;
                                w_head_req.wr_data = w_ent_rd.link;
                                n_state            = chm_pkg::S_RESP;
                            end else begin
                                n_link  = w_ent_rd.link;
                                n_state = chm_pkg::S_UNLINK;
                            end
                        end
                        default: begin
                            n_state = chm_pkg::S_RESP;
                        end
                    endcase
                end else if (w_ent_rd.link >= chm_pkg::NIL) begin
                    w_ent_req.rd_addr = r_free[chm_pkg::SLOT_W-1:0];
                    n_status          = w_miss_status;
                    n_state           = w_miss_state;
                end else begin
                    w_ent_req.rd_addr = w_ent_rd.link[chm_pkg::SLOT_W-1:0];
                    n_prev            = r_cur;
                    n_cur             = w_ent_rd.link;
                end
            end

            chm_pkg::S_ALLOC: begin
                // Pop the free slot and place it at the head of the bucket
                w_ent_req.wr_addr  = r_free[chm_pkg::SLOT_W-1:0];
                w_ent_req.key_we   = 1'b1;
                w_ent_req.val_we   = 1'b1;
                w_ent_req.link_we  = 1'b1;
                w_ent_req.wr_key   = r_key;
                w_ent_req.wr_val   = r_data;
                w_ent_req.wr_link  = r_head;
                w_head_req.wr_en   = 1'b1;
                w_head_req.wr_data = r_free;
                n_free             = w_ent_rd.link;
                n_total            = r_total + chm_pkg::IDX_W'(1);
                n_state            = chm_pkg::S_RESP;
            end

            chm_pkg::S_UNLINK: begin
                w_ent_req.wr_addr = r_prev[chm_pkg::SLOT_W-1:0];
                w_ent_req.link_we = 1'b1;
                w_ent_req.wr_link = r_link;
                n_state           = chm_pkg::S_RESP;
            end

            chm_pkg::S_RESP: begin
                if (w_out_load) begin
                    n_state = chm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = chm_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: load a finished request, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_value  <= r_value;
            r_out_count  <= chm_pkg::CNT_W'(r_total);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found        = r_out_found;
    assign o_read_value   = r_out_value;
    assign o_live_entries = r_out_count;

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= chm_pkg::IDX_W'(chm_pkg::CAPACITY))
        else $error("live entry count exceeds capacity");

    a_free_vs_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= chm_pkg::NIL) == (r_total == chm_pkg::IDX_W'(chm_pkg::CAPACITY)))
        else $error("free list state disagrees with live entry count");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == chm_pkg::S_HEAD))
        else $error("accepted request did not start a head read");

    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chm_pkg::S_RESP && r_out_valid && !i_ready)
        |=> (r_state == chm_pkg::S_RESP && r_out_valid))
        else $error("result overwrote a pending output");
`endif

endmodule

// ----- hdl/chm_heads.sv -----
// ============================================================================
// chm_heads
// Bucket head memory: one chain head per bucket, registered read. A valid
// bit per bucket makes every unwritten or cleared bucket read as empty.
// ============================================================================
module chm_heads (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  chm_pkg::t_head_req         i_req,
    output logic [chm_pkg::IDX_W-1:0]  o_rd_data
);

    logic [chm_pkg::IDX_W-1:0] r_mem [chm_pkg::BUCKETS];
    logic [chm_pkg::BUCKETS-1:0] r_vld;
    logic [chm_pkg::IDX_W-1:0] r_rd_data;
    logic                      r_rd_vld;

    // Write and read the head array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_vld  <= r_vld[i_req.rd_addr];
    end

    // Drop all heads on reset or clear, mark written buckets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : chm_pkg::NIL;

endmodule

// ----- hdl/chm_entries.sv -----
// ============================================================================
// chm_entries
// Entry pool memory: key, value and link per slot, registered read. A valid
// bit per link makes an unwritten link read as the next slot, which forms
// the initial free list.
// ============================================================================
module chm_entries (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chm_pkg::t_ent_req i_req,
    output chm_pkg::t_ent_rd  o_rd
);

    logic [chm_pkg::KEY_W-1:0]  r_key_mem  [chm_pkg::CAPACITY];
    logic [chm_pkg::VAL_W-1:0]  r_val_mem  [chm_pkg::CAPACITY];
    logic [chm_pkg::IDX_W-1:0]  r_link_mem [chm_pkg::CAPACITY];
    logic [chm_pkg::CAPACITY-1:0] r_link_vld;

    logic [chm_pkg::KEY_W-1:0]  r_rd_key;
    logic [chm_pkg::VAL_W-1:0]  r_rd_val;
    logic [chm_pkg::IDX_W-1:0]  r_rd_link;
    logic                       r_rd_lvld;
    logic [chm_pkg::SLOT_W-1:0] r_rd_addr;

    // Write fields by enable, read all fields at one address
    always_ff @(posedge i_clk) begin
        if (i_req.key_we) begin
            r_key_mem[i_req.wr_addr] <= i_req.wr_key;
        end
        if (i_req.val_we) begin
            r_val_mem[i_req.wr_addr] <= i_req.wr_val;
        end
        if (i_req.link_we) begin
            r_link_mem[i_req.wr_addr] <= i_req.wr_link;
        end
        r_rd_key  <= r_key_mem[i_req.rd_addr];
        r_rd_val  <= r_val_mem[i_req.rd_addr];
        r_rd_link <= r_link_mem[i_req.rd_addr];
        r_rd_lvld <= r_link_vld[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    // Restore the free list on reset or clear, mark written links
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_link_vld <= '0;
        end else if (i_req.link_we) begin
            r_link_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // Unwritten link points at the next slot; the last slot ends the list
    assign o_rd.key   = r_rd_key;
    assign o_rd.value = r_rd_val;
    assign o_rd.link  = r_rd_lvld ? r_rd_link
                                  : ({1'b0, r_rd_addr} + chm_pkg::IDX_W'(1));

endmodule
